// ----- src/dpf_pkg.sv -----
// Package for the deduplicating packet FIFO: field widths, command codes,
// transaction payload types and the control bundle sent to the cell row.
// No dependencies.
package dpf_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ID_PORT_W = 16;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned CNT_W     = 7;

  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned ID_BITS_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [ID_PORT_W-1:0] source;
    logic [ID_PORT_W-1:0] destination;
    logic [TS_W-1:0]      timestamp;
    logic [TS_W-1:0]      start_time;
    logic [TS_W-1:0]      end_time;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 packet_valid;
    logic [ID_PORT_W-1:0] out_source;
    logic [ID_PORT_W-1:0] out_destination;
    logic [TS_W-1:0]      out_timestamp;
    logic [CNT_W-1:0]     match_count;
  } out_item_t;

  // shift: each cell not loading a new entry takes its upper neighbor's entry (oldest drops out)
  // append: the cell at the append position loads the new entry
  typedef struct packed {
    logic shift;
    logic append;
  } cell_ctl_t;

endpackage

// ----- src/dpf_in_if.sv -----
// Command channel: valid/ready handshake carrying one command transaction.
// Depends on dpf_pkg.
interface dpf_in_if;
  logic              valid;
  logic              ready;
  dpf_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/dpf_out_if.sv -----
// Result channel: valid/ready handshake carrying one result transaction.
// Depends on dpf_pkg.
interface dpf_out_if;
  logic               valid;
  logic               ready;
  dpf_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/dedup_packet_fifo_with_range_count.sv -----
// Deduplicating packet FIFO with destination/time-range count.
// One command at a time: a new command is accepted only once the result of the
// last one is registered. The result waits for the duplicate flag and match
// count to ripple one slot per cycle along the row, and for a free result register.
// Reset empties the FIFO and sets capacity to DEPTH; entries are not cleared.
module dedup_packet_fifo_with_range_count #(
  parameter int unsigned DEPTH   = dpf_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS = dpf_pkg::ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  dpf_in_if.sink                    in_if,
  dpf_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [dpf_pkg::CAP_W-1:0] cfg_wdata
);
  import dpf_pkg::*;

  localparam int unsigned ID_W  = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_t;

  state_t           state_r;
  logic [OCC_W-1:0] scan_cnt_r;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  out_item_t        out_r;
  out_item_t        res_nxt;

  logic [CMD_W-1:0] q_cmd_r;
  logic [ID_W-1:0]  q_src_r;
  logic [ID_W-1:0]  q_dst_r;
  logic [TS_W-1:0]  q_ts_r;
  logic [TS_W-1:0]  q_lo_r;
  logic [TS_W-1:0]  q_hi_r;

  logic [ID_W-1:0]  ent_src [DEPTH];
  logic [ID_W-1:0]  ent_dst [DEPTH];
  logic [TS_W-1:0]  ent_ts  [DEPTH];
  logic [CNT_W-1:0] acc     [DEPTH];
  logic             dup     [DEPTH];

  cell_ctl_t        ctl;
  logic [IDX_W-1:0] app_pos;
  logic             commit;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_min1;
  logic [CMP_W-1:0] eff_cap;
  logic             evict;

  assign in_if.ready    = (state_r == ST_IDLE) && rst_n;
  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_r;

  assign commit = (state_r == ST_SCAN) && (scan_cnt_r == OCC_W'(DEPTH)) &&
                  (!out_valid_r || out_if.ready);

  // Capacity 0 acts as 1, anything above DEPTH acts as DEPTH
  assign cap_ext  = CMP_W'(cap_r);
  assign cap_min1 = (cap_ext == '0) ? CMP_W'(1) : cap_ext;
  assign eff_cap  = (cap_min1 > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_min1;
  assign evict    = (CMP_W'(occ_r) >= eff_cap) && (occ_r != '0);

  always_comb begin
    ctl     = '0;
    app_pos = IDX_W'(occ_r);
    occ_nxt = occ_r;
    res_nxt = '0;
    case (q_cmd_r)
      CMD_ADD: begin
        if (!dup[DEPTH-1]) begin
          res_nxt.accepted = 1'b1;
          ctl.append = commit;
          if (evict) begin
            ctl.shift = commit;
            app_pos   = IDX_W'(occ_r - OCC_W'(1));
          end else begin
            occ_nxt = occ_r + OCC_W'(1);
          end
        end
      end
      CMD_FORWARD: begin
        if (occ_r != '0) begin
          res_nxt.packet_valid    = 1'b1;
          res_nxt.out_source      = ID_PORT_W'(ent_src[0]);
          res_nxt.out_destination = ID_PORT_W'(ent_dst[0]);
          res_nxt.out_timestamp   = ent_ts[0];
          ctl.shift = commit;
          occ_nxt   = occ_r - OCC_W'(1);
        end
      end
      CMD_COUNT: begin
        res_nxt.match_count = acc[DEPTH-1];
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]  nb_src;
    logic [ID_W-1:0]  nb_dst;
    logic [TS_W-1:0]  nb_ts;
    logic [CNT_W-1:0] acc_in;
    logic             dup_in;

    if (i == DEPTH - 1) begin : g_top
      assign nb_src = '0;
      assign nb_dst = '0;
      assign nb_ts  = '0;
    end else begin : g_mid
      assign nb_src = ent_src[i+1];
      assign nb_dst = ent_dst[i+1];
      assign nb_ts  = ent_ts[i+1];
    end

    if (i == 0) begin : g_first
      assign acc_in = '0;
      assign dup_in = 1'b0;
    end else begin : g_rest
      assign acc_in = acc[i-1];
      assign dup_in = dup[i-1];
    end

    dpf_cell #(
      .POS   (i),
      .ID_W  (ID_W),
      .OCC_W (OCC_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (occ_r),
      .app_pos (app_pos),
      .q_src   (q_src_r),
      .q_dst   (q_dst_r),
      .q_ts    (q_ts_r),
      .q_lo    (q_lo_r),
      .q_hi    (q_hi_r),
      .nb_src  (nb_src),
      .nb_dst  (nb_dst),
      .nb_ts   (nb_ts),
      .acc_in  (acc_in),
      .dup_in  (dup_in),
      .ent_src (ent_src[i]),
      .ent_dst (ent_dst[i]),
      .ent_ts  (ent_ts[i]),
      .acc_out (acc[i]),
      .dup_out (dup[i])
    );
  end

  // Query capture and result register carry no reset
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      q_cmd_r <= in_if.payload.command;
      q_src_r <= in_if.payload.source[ID_W-1:0];
      q_dst_r <= in_if.payload.destination[ID_W-1:0];
      q_ts_r  <= in_if.payload.timestamp;
      q_lo_r  <= in_if.payload.start_time;
      q_hi_r  <= in_if.payload.end_time;
    end
    if (commit) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      occ_r       <= '0;
      cap_r       <= CAP_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_valid_r && out_if.ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            state_r    <= ST_SCAN;
            scan_cnt_r <= '0;
          end
        end
        ST_SCAN: begin
          if (commit) begin
            state_r     <= ST_IDLE;
            occ_r       <= occ_nxt;
            out_valid_r <= 1'b1;
          end else if (scan_cnt_r != OCC_W'(DEPTH)) begin
            // advance until the flag and count reach the last slot
            scan_cnt_r <= scan_cnt_r + OCC_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/dpf_cell.sv -----
// One slot of the FIFO row: holds an entry, compares it against the query
// and passes the running duplicate flag and match count to the next slot.
// Depends on dpf_pkg.
module dpf_cell #(
  parameter int unsigned POS   = 0,
  parameter int unsigned ID_W  = 16,
  parameter int unsigned OCC_W = 7,
  parameter int unsigned IDX_W = 6
) (
  input  logic                  clk,
  input  dpf_pkg::cell_ctl_t    ctl,
  input  logic [OCC_W-1:0]      occ,
  input  logic [IDX_W-1:0]      app_pos,
  input  logic [ID_W-1:0]       q_src,
  input  logic [ID_W-1:0]       q_dst,
  input  logic [dpf_pkg::TS_W-1:0] q_ts,
  input  logic [dpf_pkg::TS_W-1:0] q_lo,
  input  logic [dpf_pkg::TS_W-1:0] q_hi,
  input  logic [ID_W-1:0]       nb_src,
  input  logic [ID_W-1:0]       nb_dst,
  input  logic [dpf_pkg::TS_W-1:0] nb_ts,
  input  logic [dpf_pkg::CNT_W-1:0] acc_in,
  input  logic                  dup_in,
  output logic [ID_W-1:0]       ent_src,
  output logic [ID_W-1:0]       ent_dst,
  output logic [dpf_pkg::TS_W-1:0] ent_ts,
  output logic [dpf_pkg::CNT_W-1:0] acc_out,
  output logic                  dup_out
);
  import dpf_pkg::*;

  logic [ID_W-1:0]  src_r;
  logic [ID_W-1:0]  dst_r;
  logic [TS_W-1:0]  ts_r;
  logic [CNT_W-1:0] acc_r;
  logic             dup_r;
  logic             held;
  logic             dup_hit;
  logic             cnt_hit;
  logic             load_new;

  assign held     = OCC_W'(POS) < occ;
  assign dup_hit  = held && (src_r == q_src) && (dst_r == q_dst) && (ts_r == q_ts);
  assign cnt_hit  = held && (dst_r == q_dst) && (ts_r >= q_lo) && (ts_r <= q_hi);
  assign load_new = ctl.append && (app_pos == IDX_W'(POS));

  always_ff @(posedge clk) begin
    acc_r <= acc_in + CNT_W'(cnt_hit);
    dup_r <= dup_in | dup_hit;
    if (load_new) begin
      src_r <= q_src;
      dst_r <= q_dst;
      ts_r  <= q_ts;
    end else if (ctl.shift) begin
      src_r <= nb_src;
      dst_r <= nb_dst;
      ts_r  <= nb_ts;
    end
  end

  assign ent_src = src_r;
  assign ent_dst = dst_r;
  assign ent_ts  = ts_r;
  assign acc_out = acc_r;
  assign dup_out = dup_r;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the deduplicating packet FIFO with range count.
// Depends on dpf_pkg, dpf_in_if, dpf_out_if and the dedup_packet_fifo_with_range_count RTL.
module tb_top;
  import dpf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int TIMEOUT_CYCLES   = 1_200_000;
  localparam int MAX_PRINTED      = 40;

  typedef enum logic [2:0] {
    PACE_STEADY, PACE_SENDER_SLOW, PACE_RECEIVER_SLOW, PACE_BOTH_SLOW, PACE_LONG_HOLD
  } pace_t;

  typedef struct packed {
    logic [ID_PORT_W-1:0] src;
    logic [ID_PORT_W-1:0] dst;
    logic [TS_W-1:0]      ts;
  } held_pkt_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  dpf_in_if  in_if ();
  dpf_out_if out_if ();

  dedup_packet_fifo_with_range_count dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // stimulus and expectation stores
  in_item_t   cmd_queue[$];
  out_item_t  pending_results[$];
  held_pkt_t  held_packets[$];
  held_pkt_t  recent_adds[$];
  int unsigned fifo_capacity = DEPTH_DEF;
  logic [TS_W-1:0] stim_clock = 32'd1000;

  pace_t pace_mode = PACE_STEADY;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left;
  bit hold_used;

  int items_pushed = 0;
  int results_seen = 0;
  int error_count = 0;
  int n_stored = 0, n_refused = 0, n_forwards = 0, n_counts = 0, n_unknown = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input int idx);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h", idx, name, got, want));
  endtask

  // Advance the FIFO state by one command and return the result it produces.
  function automatic out_item_t predict_fifo_result(in_item_t cmd);
    out_item_t res;
    held_pkt_t pkt;
    int unsigned cap_eff;
    int unsigned hits;
    bit dup;
    res = '0;
    pkt = '{src: cmd.source, dst: cmd.destination, ts: cmd.timestamp};
    cap_eff = (fifo_capacity == 0) ? 1 : (fifo_capacity > DEPTH_DEF ? DEPTH_DEF : fifo_capacity);
    case (cmd.command)
      CMD_ADD: begin
        dup = 1'b0;
        foreach (held_packets[k])
          if (held_packets[k] == pkt) dup = 1'b1;
        if (dup) begin
          n_refused++;
        end else begin
          // evict one oldest only, even if capacity was lowered below occupancy
          if (held_packets.size() >= cap_eff && held_packets.size() > 0)
            void'(held_packets.pop_front());
          held_packets = {held_packets, pkt};
          res.accepted = 1'b1;
          n_stored++;
        end
      end
      CMD_FORWARD: begin
        n_forwards++;
        if (held_packets.size() > 0) begin
          pkt = held_packets.pop_front();
          res.packet_valid    = 1'b1;
          res.out_source      = pkt.src;
          res.out_destination = pkt.dst;
          res.out_timestamp   = pkt.ts;
        end
      end
      CMD_COUNT: begin
        n_counts++;
        hits = 0;
        foreach (held_packets[k])
          if (held_packets[k].dst == cmd.destination && held_packets[k].ts >= cmd.start_time &&
              held_packets[k].ts <= cmd.end_time)
            hits++;
        res.match_count = hits[CNT_W-1:0];
      end
      default: n_unknown++;
    endcase
    return res;
  endfunction

  // Build a command; fields the command ignores get random noise.
  function automatic in_item_t make_cmd(logic [CMD_W-1:0] op, logic [15:0] src,
                                        logic [15:0] dst, logic [31:0] ts,
                                        logic [31:0] lo, logic [31:0] hi);
    in_item_t c;
    c.command     = op;
    c.source      = (op == CMD_ADD) ? src : 16'($urandom);
    c.destination = (op == CMD_ADD || op == CMD_COUNT) ? dst : 16'($urandom);
    c.timestamp   = (op == CMD_ADD) ? ts : $urandom;
    c.start_time  = (op == CMD_COUNT) ? lo : $urandom;
    c.end_time    = (op == CMD_COUNT) ? hi : $urandom;
    return c;
  endfunction

  function automatic in_item_t random_cmd();
    int unsigned pick;
    int unsigned w;
    logic [15:0] src, dst;
    logic [31:0] ts, lo, hi;
    held_pkt_t pkt;
    pick = $urandom_range(99);
    src = ($urandom_range(99) < 60) ? 16'($urandom_range(3)) : 16'($urandom);
    dst = ($urandom_range(99) < 60) ? 16'($urandom_range(3)) : 16'($urandom);
    if (pick < 45) begin
      if (recent_adds.size() > 0 && $urandom_range(3) == 0) begin
        // replay a recent triple to provoke the duplicate filter
        pkt = recent_adds[$urandom_range(recent_adds.size() - 1)];
      end else begin
        if ($urandom_range(99) < 85) begin
          stim_clock += $urandom_range(2);
          ts = stim_clock;
        end else begin
          ts = $urandom;
        end
        pkt = '{src: src, dst: dst, ts: ts};
      end
      recent_adds = {recent_adds, pkt};
      if (recent_adds.size() > 16) void'(recent_adds.pop_front());
      return make_cmd(CMD_ADD, pkt.src, pkt.dst, pkt.ts, 0, 0);
    end else if (pick < 70) begin
      return make_cmd(CMD_FORWARD, 0, 0, 0, 0, 0);
    end else if (pick < 95) begin
      w = $urandom_range(99);
      if (w < 45) begin
        lo = stim_clock - $urandom_range(30);
        hi = lo + $urandom_range(30);
      end else if (w < 60) begin
        lo = stim_clock;
        hi = lo - 1 - $urandom_range(5);
      end else if (w < 75) begin
        lo = '0;
        hi = '1;
      end else begin
        lo = $urandom;
        hi = $urandom;
      end
      return make_cmd(CMD_COUNT, 0, dst, 0, lo, hi);
    end
    return make_cmd(CMD_UNKNOWN, 0, 0, 0, 0, 0);
  endfunction

  task automatic queue_cmd(input in_item_t c);
    cmd_queue = {cmd_queue, c};
    items_pushed++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (results_seen != items_pushed) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fifo_capacity = v;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input pace_t pace, input int n,
                           input bit pause_midway);
    wait_drained();
    write_capacity(cap);
    pace_mode = pace;
    case (pace)
      PACE_SENDER_SLOW:   begin send_idle_pct = 70; recv_stall_pct = 0;  end
      PACE_RECEIVER_SLOW: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      PACE_BOTH_SLOW:     begin send_idle_pct = 20; recv_stall_pct = 20; end
      default:            begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
    for (int i = 0; i < n; i++) begin
      // hold the sender back until every outstanding result is in
      if (pause_midway && i == n / 2) wait_drained();
      queue_cmd(random_cmd());
    end
  endtask

  // Command driver: offer the next transaction, hold it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        pending_results = {pending_results, predict_fifo_result(in_if.payload)};
      if (!in_if.valid || in_if.ready) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= cmd_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_used    <= 1'b0;
    end else if (pace_mode == PACE_LONG_HOLD && !hold_used) begin
      out_if.ready <= 1'b0;
      hold_left    <= LONG_HOLD_CYCLES;
      hold_used    <= 1'b1;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no command outstanding",
                                  results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(got.accepted), 32'(want.accepted), results_seen);
        check_field("packet_valid", 32'(got.packet_valid), 32'(want.packet_valid),
                    results_seen);
        check_field("out_source", 32'(got.out_source), 32'(want.out_source), results_seen);
        check_field("out_destination", 32'(got.out_destination), 32'(want.out_destination),
                    results_seen);
        check_field("out_timestamp", got.out_timestamp, want.out_timestamp, results_seen);
        check_field("match_count", 32'(got.match_count), 32'(want.match_count),
                    results_seen);
      end
      results_seen++;
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Timeout: %0d of %0d results received", results_seen, items_pushed);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] fill_dst;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty FIFO, extremes, duplicates, range edges, unknown command
    write_capacity(7'd64);
    queue_cmd(make_cmd(CMD_FORWARD, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_COUNT, 0, 16'h0000, 0, 32'h0, 32'hFFFF_FFFF));
    queue_cmd(make_cmd(CMD_ADD, 16'h0000, 16'h0000, 32'h0, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 16'h0000, 16'h0000, 32'h0, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 16'h0000, 16'h0000, 32'h1, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 16'h0001, 16'h0000, 32'h0, 0, 0));
    queue_cmd(make_cmd(CMD_COUNT, 0, 16'hFFFF, 0, 32'h0, 32'hFFFF_FFFF));
    queue_cmd(make_cmd(CMD_COUNT, 0, 16'h0000, 0, 32'h0, 32'h0));
    queue_cmd(make_cmd(CMD_COUNT, 0, 16'h0000, 0, 32'h1, 32'h0));
    queue_cmd(make_cmd(CMD_COUNT, 0, 16'h0000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_cmd(make_cmd(CMD_UNKNOWN, 0, 0, 0, 0, 0));
    repeat (5) queue_cmd(make_cmd(CMD_FORWARD, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 16'h0007, 16'h0005, 32'd10, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 16'h0007, 16'h0005, 32'd20, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 16'h0007, 16'h0005, 32'd30, 0, 0));
    queue_cmd(make_cmd(CMD_COUNT, 0, 16'h0005, 0, 32'd15, 32'd25));
    queue_cmd(make_cmd(CMD_COUNT, 0, 16'h0005, 0, 32'd10, 32'd30));
    queue_cmd(make_cmd(CMD_COUNT, 0, 16'h0006, 0, 32'd10, 32'd30));

    // fill to capacity with one destination, count the full set, then evict
    wait_drained();
    fill_dst = 16'($urandom);
    for (int i = 0; i < DEPTH_DEF; i++)
      queue_cmd(make_cmd(CMD_ADD, 16'(i), fill_dst, stim_clock + i, 0, 0));
    stim_clock += DEPTH_DEF;
    queue_cmd(make_cmd(CMD_COUNT, 0, fill_dst, 0, 32'h0, 32'hFFFF_FFFF));
    queue_cmd(make_cmd(CMD_ADD, 16'hBEEF, fill_dst, stim_clock, 0, 0));
    queue_cmd(make_cmd(CMD_COUNT, 0, fill_dst, 0, 32'h0, 32'hFFFF_FFFF));

    run_phase(7'd64, PACE_LONG_HOLD, 30, 1'b0);
    run_phase(7'd4, PACE_SENDER_SLOW, 280, 1'b0);
    run_phase(7'd0, PACE_RECEIVER_SLOW, 280, 1'b1);
    run_phase(7'd127, PACE_BOTH_SLOW, 280, 1'b0);
    run_phase(7'd1, PACE_STEADY, 200, 1'b0);
    run_phase(7'd65, PACE_RECEIVER_SLOW, 200, 1'b0);
    run_phase(7'($urandom_range(2, 12)), PACE_BOTH_SLOW, 200, 1'b0);
    run_phase(7'd32, PACE_STEADY, 200, 1'b0);

    wait_drained();
    repeat (DEPTH_DEF + 8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    $display("Checked %0d results: %0d adds stored, %0d refused as duplicates,", results_seen,
             n_stored, n_refused);
    $display("  %0d forwards, %0d counts, %0d unknown commands, 9 capacity settings",
             n_forwards, n_counts, n_unknown);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
